// ===== hdl/ccs_pkg.sv =====
package ccs_pkg;

   localparam int unsigned VALUE_W = 31;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned MSB_W   = 5;

   typedef enum logic [1:0] {
      MODE_GROW_CAP     = 2'd0,
      MODE_CLASS_GROW   = 2'd1,
      MODE_CLASS_SHRINK = 2'd2,
      MODE_SHRINK_TRIG  = 2'd3
   } mode_type;

   typedef struct packed {
      logic              use_round;
      logic [WORD_W-1:0] early;
      logic [WORD_W-1:0] round_arg;
      logic [MSB_W-1:0]  msb;
   } mid_type;

   function automatic logic [MSB_W-1:0] msb_of(input logic [WORD_W-1:0] x);
      logic [MSB_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (x[i]) begin
            n = MSB_W'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [WORD_W-1:0] class_step(input logic [WORD_W-1:0] p);
      logic [WORD_W-1:0] s;
      if (p >= WORD_W'(64)) begin
         s = p >> 2;
      end else if (p >= WORD_W'(8)) begin
         s = p >> 1;
      end else begin
         s = p;
      end
      return s;
   endfunction

endpackage

// ===== hdl/ccs_prep.sv =====
module ccs_prep import ccs_pkg::*; (
   input  mode_type            mode,
   input  logic [VALUE_W-1:0]  value,
   output mid_type             mid
);

   logic [WORD_W-1:0] v;
   logic [MSB_W-1:0]  msb;
   logic [WORD_W-1:0] p;
   logic [WORD_W-1:0] part;
   logic [WORD_W-1:0] above;
   logic [WORD_W-1:0] grow_d;
   logic [WORD_W-1:0] trig_d;
   logic [WORD_W-1:0] shrink_u;
   logic [WORD_W-1:0] trig_r;

   assign v     = WORD_W'(value);
   assign msb   = msb_of(v);
   assign p     = WORD_W'(1) << msb;
   assign part  = class_step(p);
   assign above = v & (part - WORD_W'(1));

   always_comb begin
      if (p >= WORD_W'(64)) begin
         grow_d = p >> 2;
      end else if (p >= WORD_W'(8)) begin
         grow_d = p >> 1;
      end else begin
         grow_d = WORD_W'(4);
      end
   end

   always_comb begin
      if (v >= WORD_W'(96)) begin
         if (v >= p + (p >> 1)) begin
            trig_d = p >> 1;
         end else if (v >= p + (p >> 2)) begin
            trig_d = (p >> 2) + (p >> 3);
         end else begin
            trig_d = p >> 2;
         end
      end else if (v >= WORD_W'(80)) begin
         trig_d = WORD_W'(32);
      end else if (v >= WORD_W'(16)) begin
         trig_d = v >> 1;
      end else begin
         trig_d = WORD_W'(8);
      end
   end

   assign trig_r = (trig_d > v) ? '0 : (v - trig_d + WORD_W'(1));

   // small shrink inputs map onto the fixed classes 4 and 8
   always_comb begin
      if (v <= WORD_W'(1)) begin
         shrink_u = WORD_W'(4);
      end else if (v <= WORD_W'(5)) begin
         shrink_u = WORD_W'(8);
      end else if (above != WORD_W'(1)) begin
         shrink_u = v + part;
      end else begin
         shrink_u = v;
      end
   end

   always_comb begin
      mid.msb = msb;
      case (mode)
         MODE_GROW_CAP: begin
            mid.use_round = 1'b0;
            mid.early     = v + grow_d;
            mid.round_arg = v;
         end
         MODE_CLASS_GROW: begin
            mid.use_round = 1'b1;
            mid.early     = '0;
            mid.round_arg = v;
         end
         MODE_CLASS_SHRINK: begin
            mid.use_round = 1'b1;
            mid.early     = '0;
            mid.round_arg = shrink_u;
         end
         default: begin
            mid.use_round = 1'b0;
            mid.early     = trig_r;
            mid.round_arg = v;
         end
      endcase
   end

endmodule

// ===== hdl/ccs_round.sv =====
module ccs_round import ccs_pkg::*; (
   input  mid_type            mid,
   output logic [WORD_W-1:0]  result
);

   logic [WORD_W-1:0] u;
   logic [WORD_W-1:0] p;
   logic [WORD_W-1:0] part;
   logic [WORD_W-1:0] above;
   logic [WORD_W-1:0] cls;

   assign u     = mid.round_arg;
   assign p     = WORD_W'(1) << msb_of(u);
   assign part  = class_step(p);
   assign above = u & (part - WORD_W'(1));

   always_comb begin
      if (u <= WORD_W'(4)) begin
         cls = WORD_W'(4);
      end else if (u <= WORD_W'(8)) begin
         cls = WORD_W'(8);
      end else if (above == '0) begin
         cls = u;
      end else begin
         cls = u + (part - above);
      end
   end

   assign result = mid.use_round ? cls : mid.early;

endmodule

// ===== hdl/container_capacity_sizing_core.sv =====
// Capacity sizing core: each transaction carries a mode (req_tuser) and a
// 31-bit size or capacity (req_tdata); it returns the sizing answer and the
// index of the value's highest set bit on rsp_tdata. One transaction is
// accepted every cycle while the pipeline is not stalled; the answer
// passes from the input register that takes the transaction through the stage
// register between bit scan/adjust and class rounding to the result register.
// Backpressure on rsp_tready stalls the pipeline once its stages are full; no
// reset-time sweep, the core is ready right after reset.
module container_capacity_sizing_core import ccs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] value, [31] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] result, [36:32] msb_index, [39:37] zero
);

   logic               in_v_ff,  in_v_in;
   logic               mid_v_ff, mid_v_in;
   logic               out_v_ff, out_v_in;
   mode_type           mode_ff;
   logic [VALUE_W-1:0] value_ff;
   mid_type            mid_ff;
   mid_type            mid_comb;
   logic [WORD_W-1:0]  result_ff;
   logic [MSB_W-1:0]   msb_ff;
   logic [WORD_W-1:0]  result_comb;
   logic               out_adv, mid_adv, in_adv;

   assign out_adv = !out_v_ff || rsp_tready;
   assign mid_adv = !mid_v_ff || out_adv;
   assign in_adv  = !in_v_ff || mid_adv;

   assign in_v_in  = in_adv  ? req_tvalid : in_v_ff;
   assign mid_v_in = mid_adv ? in_v_ff    : mid_v_ff;
   assign out_v_in = out_adv ? mid_v_ff   : out_v_ff;

   ccs_prep u_prep (
      .mode  (mode_ff),
      .value (value_ff),
      .mid   (mid_comb)
   );

   ccs_round u_round (
      .mid    (mid_ff),
      .result (result_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         mode_ff  <= mode_type'(req_tuser);
         value_ff <= req_tdata[VALUE_W-1:0];
      end
      if (mid_adv) begin
         mid_ff <= mid_comb;
      end
      if (out_adv) begin
         result_ff <= result_comb;
         msb_ff    <= mid_ff.msb;
      end
   end

   assign req_tready = in_adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b000, msb_ff, result_ff};

endmodule

// ===== bench/container_capacity_sizing_core_check.sv =====
`timescale 1ns / 1ps

module container_capacity_sizing_core_check import ccs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] value, [31] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] result, [36:32] msb_index, [39:37] zero
   output int          failures,
   output int          pending
);

   typedef struct {
      logic [WORD_W-1:0] result;
      logic [MSB_W-1:0]  msb_index;
   } sizing_answer_type;

   sizing_answer_type answer_queue[$];

   function automatic logic [MSB_W-1:0] top_bit(input logic [WORD_W-1:0] x);
      logic [MSB_W-1:0] n;
      logic             found;
      n = '0;
      found = 1'b0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!found && x[i]) begin
            n = MSB_W'(i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [WORD_W-1:0] quarter_step(input logic [WORD_W-1:0] p);
      if (p >= 32'd64) begin
         return p >> 2;
      end else if (p >= 32'd8) begin
         return p >> 1;
      end
      return p;
   endfunction

   function automatic logic [WORD_W-1:0] grown_capacity(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] d;
      p = 32'd1 << top_bit(v);
      if (p >= 32'd64) begin
         d = p >> 2;
      end else if (p >= 32'd8) begin
         d = p >> 1;
      end else begin
         d = 32'd4;
      end
      return v + d;
   endfunction

   function automatic logic [WORD_W-1:0] round_up_class(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] above;
      if (v <= 32'd4) begin
         return 32'd4;
      end
      if (v <= 32'd8) begin
         return 32'd8;
      end
      p = 32'd1 << top_bit(v);
      s = quarter_step(p);
      above = (v - p) & (s - 32'd1);
      return (above == '0) ? v : v + (s - above);
   endfunction

   function automatic logic [WORD_W-1:0] shrink_class(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] above;
      logic [WORD_W-1:0] u;
      if (v <= 32'd1) begin
         return 32'd4;
      end
      if (v <= 32'd5) begin
         return 32'd8;
      end
      p = 32'd1 << top_bit(v);
      s = quarter_step(p);
      above = (v - p) & (s - 32'd1);
      u = (above != 32'd1) ? v + s : v;
      return round_up_class(u);
   endfunction

   function automatic logic [WORD_W-1:0] shrink_threshold(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] d;
      if (v >= 32'd96) begin
         p = 32'd1 << top_bit(v);
         if (v >= (p >> 1) * 32'd3) begin
            d = p >> 1;
         end else if (v >= (p >> 2) * 32'd5) begin
            d = (p >> 3) * 32'd3;
         end else begin
            d = p >> 2;
         end
      end else if (v >= 32'd80) begin
         d = 32'd32;
      end else if (v >= 32'd16) begin
         d = v >> 1;
      end else begin
         d = 32'd8;
      end
      return (d > v) ? '0 : v - d + 32'd1;
   endfunction

   function automatic sizing_answer_type predict_sizing(input mode_type mode,
                                                        input logic [VALUE_W-1:0] value);
      sizing_answer_type a;
      logic [WORD_W-1:0] v;
      v = {1'b0, value};
      case (mode)
         MODE_GROW_CAP:     a.result = grown_capacity(v);
         MODE_CLASS_GROW:   a.result = round_up_class(v);
         MODE_CLASS_SHRINK: a.result = shrink_class(v);
         default:           a.result = shrink_threshold(v);
      endcase
      a.msb_index = top_bit(v);
      return a;
   endfunction

   always @(posedge clock) begin
      sizing_answer_type want;
      if (reset) begin
         failures = 0;
         pending = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            answer_queue.push_back(predict_sizing(mode_type'(req_tuser),
                                                  req_tdata[VALUE_W-1:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected transaction, actual result %h msb_index %0d",
                        $time, rsp_tdata[31:0], rsp_tdata[36:32]);
               failures++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_tdata[31:0] !== want.result) begin
                  $display("%0t: result mismatch, expected %h actual %h",
                           $time, want.result, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[36:32] !== want.msb_index) begin
                  $display("%0t: msb_index mismatch, expected %0d actual %0d",
                           $time, want.msb_index, rsp_tdata[36:32]);
                  failures++;
               end
            end
         end
         pending = answer_queue.size();
      end
   end

endmodule

// ===== bench/container_capacity_sizing_core_test.sv =====
`timescale 1ns / 1ps

module container_capacity_sizing_core_test import ccs_pkg::*;;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [30:0] value, [31] zero
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] result, [36:32] msb_index, [39:37] zero
   int          failures;
   int          pending;
   int          idle_pct;
   int          stall_pct;

   logic [VALUE_W-1:0] corner_values[6] = '{31'd0, 31'd5, 31'd80, 31'd97,
                                            31'h5fffffff, 31'h7fffffff};

   container_capacity_sizing_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   container_capacity_sizing_core_check checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("container_capacity_sizing_core_test NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // biased toward power-of-two, step and threshold edges
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [31:0] p;
      logic [31:0] v;
      int          kind;
      kind = $urandom_range(9);
      p = 32'd1 << $urandom_range(30);
      case (kind)
         0, 1: v = $urandom_range(130);
         2:    v = p + $urandom_range(6) - 32'd3;
         3:    v = p + $urandom_range(3) * (p >> 2) + $urandom_range(2) - 32'd1;
         4:    v = ($urandom_range(1) ? (p >> 1) * 32'd3 : (p >> 2) * 32'd5)
                   + $urandom_range(2) - 32'd1;
         5, 6: v = $urandom;
         default: v = $urandom >> $urandom_range(31);
      endcase
      return v[VALUE_W-1:0];
   endfunction

   task automatic send(input mode_type mode, input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) begin
         send(mode_type'($urandom_range(3)), pick_value());
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_values[i]) begin
         send(MODE_GROW_CAP, corner_values[i]);
         send(MODE_CLASS_GROW, corner_values[i]);
         send(MODE_CLASS_SHRINK, corner_values[i]);
         send(MODE_SHRINK_TRIG, corner_values[i]);
      end

      run_phase(0, 0, 300);
      run_phase(80, 0, 280);
      drain();
      run_phase(0, 80, 280);
      run_phase(29, 29, 280);
      run_phase(0, 0, 260);

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("container_capacity_sizing_core_test OK");
      end else begin
         $display("container_capacity_sizing_core_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ccs_pkg.sv
hdl/ccs_prep.sv
hdl/ccs_round.sv
hdl/container_capacity_sizing_core.sv
bench/container_capacity_sizing_core_check.sv
bench/container_capacity_sizing_core_test.sv
